>>> rtl/core/sob_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// sob_pkg: shared types and constants for the Sobel orientation field unit
// Widths, register map, controller states and command/status bundles.
// ----------------------------------------------------------------------------
package sob_pkg;

    localparam int MAX_WIDTH_DEF  = 1024;
    localparam int MAX_HEIGHT_DEF = 1024;
    localparam int FRAC_BITS_DEF  = 15;

    localparam int CFG_DIM_W = 11;
    localparam int EPS_W     = 23;
    localparam int PIX_W     = 8;
    localparam int GRAD_W    = 11;
    localparam int MAG_W     = 10;
    localparam int SQ_W      = 22;
    localparam int ROOT_W    = 23;
    localparam int DEN_W     = 24;
    localparam int OUT_W     = 16;
    localparam int APB_AW    = 4;
    localparam int APB_DW    = 32;

    localparam logic [CFG_DIM_W-1:0] WIDTH_RST  = 11'd640;
    localparam logic [CFG_DIM_W-1:0] HEIGHT_RST = 11'd480;
    localparam logic [EPS_W-1:0]     EPS_RST    = 23'd1;

    localparam logic [1:0] REG_WIDTH  = 2'd0;
    localparam logic [1:0] REG_HEIGHT = 2'd1;
    localparam logic [1:0] REG_EPS    = 2'd2;

    localparam logic OP_PIXEL = 1'b0;
    localparam logic OP_DRAIN = 1'b1;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_LOAD,
        ST_SQUARE,
        ST_SUM,
        ST_SQRT,
        ST_DEN,
        ST_DIVX_INIT,
        ST_DIVX,
        ST_DIVY_INIT,
        ST_DIVY,
        ST_OUT
    } sob_state_t;

    typedef struct packed {
        logic accept;
        logic load;
        logic square;
        logic sum;
        logic sqrt_step;
        logic den;
        logic div_init;
        logic div_sel;
        logic div_step;
        logic out_write;
    } sob_cmd_t;

    typedef struct packed {
        logic skip;
        logic has_result;
        logic sqrt_done;
        logic div_done;
        logic out_full;
    } sob_status_t;

    // signed Q1.15 result from quotient magnitude, saturated
    function automatic logic [OUT_W-1:0] sat_q(input logic neg, input logic [31:0] q);
        logic [31:0] lim;
        if (neg) begin
            lim = (q > 32'd32768) ? 32'd32768 : q;
            return OUT_W'(32'd0 - lim);
        end else begin
            lim = (q > 32'd32767) ? 32'd32767 : q;
            return OUT_W'(lim);
        end
    endfunction

endpackage
`default_nettype wire

>>> rtl/core/sob_cfg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// sob_cfg: configuration register file
// APB-style slave holding frame width, frame height and epsilon.
// ----------------------------------------------------------------------------
module sob_cfg (
    input  wire logic                          aclk,
    input  wire logic                          aresetn,
    input  wire logic                          psel,
    input  wire logic                          penable,
    input  wire logic                          pwrite,
    input  wire logic [sob_pkg::APB_AW-1:0]    paddr,
    input  wire logic [sob_pkg::APB_DW-1:0]    pwdata,
    output logic      [sob_pkg::APB_DW-1:0]    prdata,
    output logic                               pready,
    output logic      [sob_pkg::CFG_DIM_W-1:0] frame_width,
    output logic      [sob_pkg::CFG_DIM_W-1:0] frame_height,
    output logic      [sob_pkg::EPS_W-1:0]     epsilon
);
    import sob_pkg::*;

    logic [CFG_DIM_W-1:0] width_reg;
    logic [CFG_DIM_W-1:0] height_reg;
    logic [EPS_W-1:0]     eps_reg;
    logic                 wr_en;
    logic [1:0]           reg_idx;

    assign pready  = 1'b1;
    assign wr_en   = psel && penable && pwrite && pready;
    assign reg_idx = paddr[3:2];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            width_reg  <= WIDTH_RST;
            height_reg <= HEIGHT_RST;
            eps_reg    <= EPS_RST;
        end else if (wr_en) begin
            unique case (reg_idx)
                REG_WIDTH:  width_reg  <= pwdata[CFG_DIM_W-1:0];
                REG_HEIGHT: height_reg <= pwdata[CFG_DIM_W-1:0];
                REG_EPS:    eps_reg    <= pwdata[EPS_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (reg_idx)
            REG_WIDTH:  prdata = APB_DW'(width_reg);
            REG_HEIGHT: prdata = APB_DW'(height_reg);
            REG_EPS:    prdata = APB_DW'(eps_reg);
            default:    prdata = '0;
        endcase
    end

    assign frame_width  = width_reg;
    assign frame_height = height_reg;
    assign epsilon      = eps_reg;

endmodule
`default_nettype wire

>>> rtl/core/sob_ctrl.sv
`default_nettype none
// ----------------------------------------------------------------------------
// sob_ctrl: sequencing controller
// Steps one item through load, square, root, and two divisions.
// ----------------------------------------------------------------------------
module sob_ctrl (
    input  wire logic                 aclk,
    input  wire logic                 aresetn,
    input  wire logic                 s_tvalid,
    output logic                      s_tready,
    input  wire sob_pkg::sob_status_t status,
    output sob_pkg::sob_cmd_t         cmd
);
    import sob_pkg::*;

    sob_state_t state_reg;
    sob_state_t state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        cmd        = '0;
        s_tready   = 1'b0;
        unique case (state_reg)
            ST_IDLE: begin
                s_tready = 1'b1;
                if (s_tvalid) begin
                    cmd.accept = 1'b1;
                    if (!status.skip) state_next = ST_LOAD;
                end
            end
            ST_LOAD: begin
                cmd.load   = 1'b1;
                state_next = status.has_result ? ST_SQUARE : ST_IDLE;
            end
            ST_SQUARE: begin
                cmd.square = 1'b1;
                state_next = ST_SUM;
            end
            ST_SUM: begin
                cmd.sum    = 1'b1;
                state_next = ST_SQRT;
            end
            ST_SQRT: begin
                cmd.sqrt_step = 1'b1;
                if (status.sqrt_done) state_next = ST_DEN;
            end
            ST_DEN: begin
                cmd.den    = 1'b1;
                state_next = ST_DIVX_INIT;
            end
            ST_DIVX_INIT: begin
                cmd.div_init = 1'b1;
                state_next   = ST_DIVX;
            end
            ST_DIVX: begin
                cmd.div_step = 1'b1;
                if (status.div_done) state_next = ST_DIVY_INIT;
            end
            ST_DIVY_INIT: begin
                cmd.div_init = 1'b1;
                cmd.div_sel  = 1'b1;
                state_next   = ST_DIVY;
            end
            ST_DIVY: begin
                cmd.div_step = 1'b1;
                cmd.div_sel  = 1'b1;
                if (status.div_done) state_next = ST_OUT;
            end
            ST_OUT: begin
                if (!status.out_full) begin
                    cmd.out_write = 1'b1;
                    state_next    = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

endmodule
`default_nettype wire

>>> rtl/core/sob_dp.sv
`default_nettype none
// ----------------------------------------------------------------------------
// sob_dp: datapath
// Line stores, 3x3 window, raster counters, gradient, bit-serial square root,
// shared restoring divider and output register.
// ----------------------------------------------------------------------------
module sob_dp #(
    parameter int MAX_WIDTH  = sob_pkg::MAX_WIDTH_DEF,
    parameter int MAX_HEIGHT = sob_pkg::MAX_HEIGHT_DEF,
    parameter int FRAC_BITS  = sob_pkg::FRAC_BITS_DEF
) (
    input  wire logic                          aclk,
    input  wire logic                          aresetn,
    input  wire logic [sob_pkg::CFG_DIM_W-1:0] frame_width,
    input  wire logic [sob_pkg::CFG_DIM_W-1:0] frame_height,
    input  wire logic [sob_pkg::EPS_W-1:0]     epsilon,
    input  wire logic                          s_tuser,
    input  wire logic [7:0]                    s_tdata,
    input  wire sob_pkg::sob_cmd_t             cmd,
    output sob_pkg::sob_status_t               status,
    output logic                               m_tvalid,
    input  wire logic                          m_tready,
    output logic      [31:0]                   m_tdata,
    output logic                               m_tlast
);
    import sob_pkg::*;

    localparam int AW     = $clog2(MAX_WIDTH);
    localparam int CW     = $clog2(MAX_WIDTH + 1);
    localparam int RW     = $clog2(MAX_HEIGHT + 1);
    localparam int QW     = FRAC_BITS + 2;
    localparam int NSH    = FRAC_BITS + 12;
    localparam int NW     = MAG_W + NSH + 1;
    localparam int RM     = ROOT_W + 2;
    localparam int ITER_N = (QW > ROOT_W) ? QW : ROOT_W;
    localparam int IW     = $clog2(ITER_N);

    typedef logic [2:0][PIX_W-1:0] col_t;

    function automatic logic [MAG_W-1:0] col_sum(input logic [PIX_W-1:0] a,
                                                 input logic [PIX_W-1:0] b,
                                                 input logic [PIX_W-1:0] c);
        return MAG_W'(a) + (MAG_W'(b) << 1) + MAG_W'(c);
    endfunction

    function automatic logic [MAG_W-1:0] abs_g(input logic signed [GRAD_W-1:0] g);
        logic [GRAD_W-1:0] a;
        a = g[GRAD_W-1] ? GRAD_W'(-g) : GRAD_W'(g);
        return a[MAG_W-1:0];
    endfunction

    // line stores
    logic [PIX_W-1:0] upper_mem  [MAX_WIDTH];
    logic [PIX_W-1:0] middle_mem [MAX_WIDTH];
    logic [PIX_W-1:0] up_rd_reg;
    logic [PIX_W-1:0] mid_rd_reg;

    logic [CW-1:0] col_reg;
    logic [RW-1:0] row_reg;
    logic [CW-1:0] drain_reg;
    logic [2:0][2:0][PIX_W-1:0] win_reg;

    // item context
    logic [CW-1:0]    c_reg;
    logic [PIX_W-1:0] px_reg;
    logic             at_end_reg;
    logic             old_win_reg;
    logic             eof_reg;
    logic             hasres_reg;
    logic             c_is1_reg;
    logic             r_is1_reg;

    logic signed [GRAD_W-1:0] gx_reg;
    logic signed [GRAD_W-1:0] gy_reg;
    logic [SQ_W-1:0]          sqx_reg;
    logic [SQ_W-1:0]          sqy_reg;
    logic [2*ROOT_W-1:0]      vsh_reg;
    logic [RM-1:0]            srem_reg;
    logic [ROOT_W-1:0]        root_reg;
    logic [DEN_W-1:0]         den_reg;
    logic [DEN_W-1:0]         drem_reg;
    logic [QW-1:0]            nlow_reg;
    logic [QW-1:0]            q_reg;
    logic [IW-1:0]            iter_reg;
    logic [OUT_W-1:0]         ox_reg;
    logic                     m_valid_reg;
    logic [31:0]              m_data_reg;
    logic                     m_last_reg;

    logic [CW-1:0] w_eff;
    logic [RW-1:0] h_eff;
    logic [CW-1:0] c_col;
    logic [RW-1:0] r_c;
    logic [CW-1:0] d_c;
    logic [CW-1:0] c_sel;
    logic [CW-1:0] c_inc;
    logic          at_end;
    logic          pre;
    logic          eofc;
    logic          emitn;

    always_comb begin
        if (frame_width < CFG_DIM_W'(3))            w_eff = CW'(3);
        else if (32'(frame_width) > 32'(MAX_WIDTH)) w_eff = CW'(MAX_WIDTH);
        else                                        w_eff = CW'(frame_width);
        if (frame_height < CFG_DIM_W'(3))             h_eff = RW'(3);
        else if (32'(frame_height) > 32'(MAX_HEIGHT)) h_eff = RW'(MAX_HEIGHT);
        else                                          h_eff = RW'(frame_height);
        c_col  = (col_reg >= w_eff) ? CW'(w_eff - CW'(1)) : col_reg;
        r_c    = (row_reg >= h_eff) ? h_eff : row_reg;
        d_c    = (drain_reg > w_eff) ? w_eff : drain_reg;
        at_end = (r_c == h_eff);
        c_sel  = at_end ? d_c : c_col;
        c_inc  = CW'(c_sel + CW'(1));
        pre    = (c_sel == '0) && (r_c >= RW'(2));
        eofc   = at_end && (c_sel == w_eff);
        emitn  = (c_sel != '0) && (r_c != '0);
    end

    assign status.skip = at_end ? (s_tuser == OP_PIXEL) : (s_tuser == OP_DRAIN);

    // accept: counters, context, line store read
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            col_reg   <= '0;
            row_reg   <= '0;
            drain_reg <= '0;
        end else if (cmd.accept) begin
            col_reg   <= c_col;
            row_reg   <= r_c;
            drain_reg <= d_c;
            if (!status.skip) begin
                if (eofc) begin
                    col_reg   <= '0;
                    row_reg   <= '0;
                    drain_reg <= '0;
                end else if (at_end) begin
                    drain_reg <= c_inc;
                end else if (c_inc >= w_eff) begin
                    col_reg   <= '0;
                    row_reg   <= RW'(r_c + RW'(1));
                    drain_reg <= '0;
                end else begin
                    col_reg <= c_inc;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.accept) begin
            c_reg       <= c_sel;
            px_reg      <= s_tdata[PIX_W-1:0];
            at_end_reg  <= at_end;
            old_win_reg <= pre || eofc;
            eof_reg     <= eofc;
            hasres_reg  <= pre || eofc || emitn;
            c_is1_reg   <= (c_sel == CW'(1));
            r_is1_reg   <= (r_c == RW'(1));
            up_rd_reg   <= upper_mem[c_sel[AW-1:0]];
            mid_rd_reg  <= middle_mem[c_sel[AW-1:0]];
        end
        if (cmd.load && !at_end_reg && !eof_reg) begin
            upper_mem[c_reg[AW-1:0]]  <= mid_rd_reg;
            middle_mem[c_reg[AW-1:0]] <= px_reg;
        end
    end

    assign status.has_result = hasres_reg;

    // window shift and gradient
    logic [PIX_W-1:0] top_in;
    logic [PIX_W-1:0] bot_in;
    logic [2:0][2:0][PIX_W-1:0] win_new;
    col_t wl;
    col_t wm;
    col_t wr;

    always_comb begin
        bot_in     = at_end_reg ? up_rd_reg : px_reg;
        top_in     = r_is1_reg ? bot_in : up_rd_reg;
        win_new[0] = win_reg[1];
        win_new[1] = win_reg[2];
        win_new[2] = {bot_in, mid_rd_reg, top_in};
        if (old_win_reg) begin
            wl = win_reg[1];
            wm = win_reg[2];
            wr = win_reg[1];
        end else begin
            wl = c_is1_reg ? win_new[2] : win_new[0];
            wm = win_new[1];
            wr = win_new[2];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            win_reg <= '0;
        end else if (cmd.load && !eof_reg) begin
            win_reg <= win_new;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            gx_reg <= $signed({1'b0, col_sum(wr[0], wr[1], wr[2])})
                    - $signed({1'b0, col_sum(wl[0], wl[1], wl[2])});
            gy_reg <= $signed({1'b0, col_sum(wl[2], wm[2], wr[2])})
                    - $signed({1'b0, col_sum(wl[0], wm[0], wr[0])});
        end
        if (cmd.square) begin
            sqx_reg <= SQ_W'(abs_g(gx_reg)) * SQ_W'(abs_g(gx_reg));
            sqy_reg <= SQ_W'(abs_g(gy_reg)) * SQ_W'(abs_g(gy_reg));
        end
    end

    // square root, two radicand bits per step
    logic [RM+1:0] s_rem2;
    logic [RM+1:0] s_trial;
    logic          s_ge;

    always_comb begin
        s_rem2  = {srem_reg, vsh_reg[2*ROOT_W-1 -: 2]};
        s_trial = (RM + 2)'({root_reg, 2'b01});
        s_ge    = (s_rem2 >= s_trial);
    end

    // restoring divider, one quotient bit per step
    logic [MAG_W-1:0] d_mag;
    logic [NW-1:0]    d_num;
    logic [DEN_W:0]   d_rem2;
    logic             d_ge;

    always_comb begin
        d_mag  = cmd.div_sel ? abs_g(gy_reg) : abs_g(gx_reg);
        d_num  = (NW'(d_mag) << NSH) + NW'(den_reg >> 1);
        d_rem2 = {drem_reg, nlow_reg[QW-1]};
        d_ge   = (d_rem2 >= {1'b0, den_reg});
    end

    always_ff @(posedge aclk) begin
        if (cmd.sum) begin
            vsh_reg  <= {SQ_W'(sqx_reg + sqy_reg), 24'd0};
            srem_reg <= '0;
            root_reg <= '0;
            iter_reg <= '0;
        end
        if (cmd.sqrt_step) begin
            vsh_reg  <= vsh_reg << 2;
            iter_reg <= IW'(iter_reg + IW'(1));
            if (s_ge) begin
                srem_reg <= RM'(s_rem2 - s_trial);
                root_reg <= {root_reg[ROOT_W-2:0], 1'b1};
            end else begin
                srem_reg <= RM'(s_rem2);
                root_reg <= {root_reg[ROOT_W-2:0], 1'b0};
            end
        end
        if (cmd.den) begin
            den_reg <= DEN_W'(root_reg) + DEN_W'(epsilon);
        end
        if (cmd.div_init) begin
            drem_reg <= DEN_W'(d_num >> QW);
            nlow_reg <= d_num[QW-1:0];
            q_reg    <= '0;
            iter_reg <= '0;
            if (cmd.div_sel) begin
                ox_reg <= (den_reg == '0) ? '0 : sat_q(gx_reg[GRAD_W-1], 32'(q_reg));
            end
        end
        if (cmd.div_step) begin
            nlow_reg <= nlow_reg << 1;
            iter_reg <= IW'(iter_reg + IW'(1));
            if (d_ge) begin
                drem_reg <= DEN_W'(d_rem2 - {1'b0, den_reg});
                q_reg    <= {q_reg[QW-2:0], 1'b1};
            end else begin
                drem_reg <= d_rem2[DEN_W-1:0];
                q_reg    <= {q_reg[QW-2:0], 1'b0};
            end
        end
    end

    assign status.sqrt_done = (iter_reg == IW'(ROOT_W - 1));
    assign status.div_done  = (iter_reg == IW'(QW - 1));

    // output register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (cmd.out_write) begin
            m_valid_reg <= 1'b1;
        end else if (m_tready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.out_write) begin
            m_data_reg <= {(den_reg == '0) ? OUT_W'(0) : sat_q(gy_reg[GRAD_W-1], 32'(q_reg)),
                           ox_reg};
            m_last_reg <= eof_reg;
        end
    end

    assign status.out_full = m_valid_reg && !m_tready;
    assign m_tvalid        = m_valid_reg;
    assign m_tdata         = m_data_reg;
    assign m_tlast         = m_last_reg;

endmodule
`default_nettype wire

>>> rtl/core/sobel_unit_orientation_field_top.sv
`default_nettype none
// Sequence: after acceptance a result item passes through load, square, sum, root steps,
//   denominator, the x and y divides and the output write, in that order.
// Flow: one item at a time; the input is ready only in idle, so a new item is accepted
//   only after the last is done, output stalls included. Items with no result end early.
// Reset: synchronous active-low aresetn clears counters, window, controller, output
//   valid and registers to their defaults; line stores are not cleared.
// ----------------------------------------------------------------------------
// sobel_unit_orientation_field_top: Sobel normalized gradient orientation
// Streams raster pixels in, emits gx and gy over (magnitude + epsilon) in Q1.15.
// ----------------------------------------------------------------------------
module sobel_unit_orientation_field_top #(
    parameter int MAX_WIDTH  = sob_pkg::MAX_WIDTH_DEF,
    parameter int MAX_HEIGHT = sob_pkg::MAX_HEIGHT_DEF,
    parameter int FRAC_BITS  = sob_pkg::FRAC_BITS_DEF
) (
    input  wire logic                       aclk,
    input  wire logic                       aresetn,
    input  wire logic                       s_tvalid,
    output logic                            s_tready,
    input  wire logic [7:0]                 s_tdata,  // [7:0] pixel
    input  wire logic                       s_tuser,  // [0] operation
    output logic                            m_tvalid,
    input  wire logic                       m_tready,
    output logic      [31:0]                m_tdata,  // [15:0] orient_x, [31:16] orient_y
    output logic                            m_tlast,
    input  wire logic                       psel,
    input  wire logic                       penable,
    input  wire logic                       pwrite,
    input  wire logic [sob_pkg::APB_AW-1:0] paddr,
    input  wire logic [sob_pkg::APB_DW-1:0] pwdata,
    output logic      [sob_pkg::APB_DW-1:0] prdata,
    output logic                            pready
);
    import sob_pkg::*;

    logic [CFG_DIM_W-1:0] frame_width;
    logic [CFG_DIM_W-1:0] frame_height;
    logic [EPS_W-1:0]     epsilon;
    sob_cmd_t             cmd;
    sob_status_t          status;

    sob_cfg u_cfg (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .psel         (psel),
        .penable      (penable),
        .pwrite       (pwrite),
        .paddr        (paddr),
        .pwdata       (pwdata),
        .prdata       (prdata),
        .pready       (pready),
        .frame_width  (frame_width),
        .frame_height (frame_height),
        .epsilon      (epsilon)
    );

    sob_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .status   (status),
        .cmd      (cmd)
    );

    sob_dp #(
        .MAX_WIDTH  (MAX_WIDTH),
        .MAX_HEIGHT (MAX_HEIGHT),
        .FRAC_BITS  (FRAC_BITS)
    ) u_dp (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .frame_width  (frame_width),
        .frame_height (frame_height),
        .epsilon      (epsilon),
        .s_tuser      (s_tuser),
        .s_tdata      (s_tdata),
        .cmd          (cmd),
        .status       (status),
        .m_tvalid     (m_tvalid),
        .m_tready     (m_tready),
        .m_tdata      (m_tdata),
        .m_tlast      (m_tlast)
    );

endmodule
`default_nettype wire

>>> rtl/core/sob_chk.sv
`default_nettype none
// ----------------------------------------------------------------------------
// sob_chk: port-level checker for the Sobel orientation field unit
// Watches the stream and configuration ports over time.
// ----------------------------------------------------------------------------
module sob_chk (
    input wire logic                       aclk,
    input wire logic                       aresetn,
    input wire logic                       s_tvalid,
    input wire logic                       s_tready,
    input wire logic [7:0]                 s_tdata,
    input wire logic                       s_tuser,
    input wire logic                       m_tvalid,
    input wire logic                       m_tready,
    input wire logic [31:0]                m_tdata,
    input wire logic                       m_tlast,
    input wire logic                       pready
);

    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast))
        else $error("result changed while stalled");

    a_in_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && !s_tready |=> s_tvalid && $stable(s_tdata) && $stable(s_tuser))
        else $error("input transaction changed while stalled");

    a_reset_idle: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("result valid after reset");

    a_new_result_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_tvalid) |-> $past(!s_tready))
        else $error("new result while input side was ready");

    a_pready: assert property (@(posedge aclk) disable iff (!aresetn)
        pready)
        else $error("pready low");

endmodule

bind sobel_unit_orientation_field_top sob_chk u_sob_chk (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast),
    .pready   (pready)
);
`default_nettype wire
